/* rtl/read_range_coalescer_macros.svh */
// assertion helpers for the range coalescer
`ifndef READ_RANGE_COALESCER_MACROS_SVH
`define READ_RANGE_COALESCER_MACROS_SVH

// property that must hold at every edge out of reset
`define RRC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// implication over the next edge
`define RRC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/rrc_pkg.sv */
package rrc_pkg;

  localparam int unsigned MaxRangesDef = 32;
  localparam int unsigned OffW         = 48;
  localparam int unsigned LenW         = 32;
  localparam int unsigned RunLenW      = 48;
  localparam int unsigned LimW         = 32;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [CfgIdxW-1:0] RegHoleLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] RegSpanLimit = 1'b1;

  localparam logic [LimW-1:0] HoleLimitRst = 32'd8192;
  localparam logic [LimW-1:0] SpanLimitRst = 32'd67108864;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [OffW-1:0] off;
  } range_t;

  typedef enum logic [3:0] {
    StLoad  = 4'b0001,
    StScan  = 4'b0010,
    StProc  = 4'b0100,
    StFlush = 4'b1000
  } state_e;

endpackage

/* rtl/read_range_coalescer.sv */
// channel   | dir | transfer moves
// s_axis    | in  | one range: tdata = offset, length; tlast = last of set
// m_axis    | out | one run: tdata = offset, length; tuser = empty, overflow; tlast
// cfg       | in  | register write: index, data
//
// loading takes one range per cycle into a single-port-write range memory.
// after the last range, each pick scans all stored ranges once to find the
// next range in offset order, then the merge state takes it in, so a set
// with m stored nonzero ranges takes m + 1 scans.
// the result register lets the next set load while the final run waits.
// no clearing pass after reset; a full result stage stalls merging only when
// a finished run has to move out.
module read_range_coalescer #(
  parameter int unsigned MAX_RANGES = rrc_pkg::MaxRangesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [79:0]                s_axis_tdata,  // range_offset[47:0], range_length[79:48]
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [95:0]                m_axis_tdata,  // run_offset[47:0], run_length[95:48]
  output logic [1:0]                 m_axis_tuser,  // empty_set[0], overflow[1]
  output logic                       m_axis_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rrc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rrc_pkg::LimW-1:0]   cfg_data
);
  import rrc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_RANGES + 1);
  localparam int unsigned IW = $clog2(MAX_RANGES);
  localparam logic [CW-1:0] CntMax = CW'(MAX_RANGES);

  state_e state_q;

  logic [LimW-1:0] hole_q, span_q;

  range_t mem [MAX_RANGES];
  range_t rd_q;
  logic [IW-1:0] rd_idx_q;
  logic rd_vld_q;

  logic [CW-1:0] cnt_q, n_q, iss_q;
  logic ovf_q, set_ovf_q;
  logic [MAX_RANGES-1:0] used_q;

  logic best_vld_q;
  logic [IW-1:0] best_idx_q;
  range_t best_q;

  logic kept_q;
  logic [OffW-1:0] run_start_q;
  logic [OffW:0] prev_end_q;

  logic out_vld_q, out_last_q, out_empty_q, out_ovf_q;
  logic [OffW-1:0] out_off_q;
  logic [RunLenW-1:0] out_len_q;

  logic in_xfer, full, out_free, issue, cand_better;
  logic [OffW:0] ce, o_ext, pe_eff, rs_ext;
  logic [OffW-1:0] rs_eff;
  logic drop, gap_big, span_big, close, emit_now, proc_stall, proc_go;
  logic flush_go, out_load, out_last_d, out_empty_d;
  logic [OffW-1:0] out_off_d;
  logic [RunLenW-1:0] out_len_d;

  assign s_axis_tready = (state_q == StLoad);
  assign cfg_ready     = 1'b1;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign full     = (cnt_q == CntMax);
  assign out_free = !out_vld_q || m_axis_tready;
  assign issue    = (state_q == StScan) && (iss_q < n_q);

  assign cand_better = rd_vld_q && !used_q[rd_idx_q] && (rd_q.len != '0) &&
                       (!best_vld_q || (rd_q.off < best_q.off) ||
                        ((rd_q.off == best_q.off) && (rd_q.len > best_q.len)));

  always_comb begin
    o_ext    = {1'b0, best_q.off};
    ce       = o_ext + {{(OffW + 1 - LenW){1'b0}}, best_q.len};
    drop     = kept_q && (ce <= prev_end_q);
    rs_eff   = kept_q ? run_start_q : best_q.off;
    rs_ext   = {1'b0, rs_eff};
    pe_eff   = kept_q ? prev_end_q : o_ext;
    gap_big  = (o_ext > pe_eff) && ((o_ext - pe_eff) > {{(OffW + 1 - LimW){1'b0}}, hole_q});
    span_big = (ce - rs_ext) > {{(OffW + 1 - LimW){1'b0}}, span_q};
    close    = gap_big || span_big;
    emit_now = !drop && close && (pe_eff > rs_ext);
    proc_stall = (state_q == StProc) && best_vld_q && emit_now && !out_free;
    proc_go    = (state_q == StProc) && best_vld_q && !proc_stall;
    flush_go   = (state_q == StFlush) && out_free;

    out_load    = 1'b0;
    out_last_d  = 1'b0;
    out_empty_d = 1'b0;
    out_off_d   = rs_eff;
    out_len_d   = RunLenW'(pe_eff - rs_ext);
    if (proc_go && emit_now) begin
      out_load = 1'b1;
    end else if (flush_go) begin
      out_load   = 1'b1;
      out_last_d = 1'b1;
      if (kept_q) begin
        // the open run is the final one
        out_off_d = run_start_q;
        out_len_d = RunLenW'(prev_end_q - {1'b0, run_start_q});
      end else begin
        out_empty_d = 1'b1;
        out_off_d   = '0;
        out_len_d   = '0;
      end
    end
  end

  // range memory, registered read
  always_ff @(posedge clk_i) begin
    if (in_xfer && !full) begin
      mem[cnt_q[IW-1:0]] <= range_t'{len: s_axis_tdata[79:48], off: s_axis_tdata[47:0]};
    end
    if (issue) begin
      rd_q <= mem[iss_q[IW-1:0]];
    end
    rd_idx_q <= iss_q[IW-1:0];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cand_better) begin
      best_q     <= rd_q;
      best_idx_q <= rd_idx_q;
    end
    if (proc_go && !drop) begin
      run_start_q <= close ? best_q.off : rs_eff;
      prev_end_q  <= ce;
    end
    if (out_load) begin
      out_off_q   <= out_off_d;
      out_len_q   <= out_len_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_ovf_q   <= set_ovf_q;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      hole_q     <= HoleLimitRst;
      span_q     <= SpanLimitRst;
      cnt_q      <= '0;
      n_q        <= '0;
      iss_q      <= '0;
      ovf_q      <= 1'b0;
      set_ovf_q  <= 1'b0;
      used_q     <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      kept_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegHoleLimit: hole_q <= cfg_data;
          RegSpanLimit: span_q <= cfg_data;
          default: ;
        endcase
      end

      rd_vld_q <= issue;
      if (issue) begin
        iss_q <= iss_q + CW'(1);
      end
      if (cand_better) begin
        best_vld_q <= 1'b1;
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        StLoad: begin
          if (in_xfer) begin
            if (s_axis_tlast) begin
              n_q        <= full ? cnt_q : cnt_q + CW'(1);
              set_ovf_q  <= ovf_q || full;
              cnt_q      <= '0;
              ovf_q      <= 1'b0;
              used_q     <= '0;
              kept_q     <= 1'b0;
              iss_q      <= '0;
              best_vld_q <= 1'b0;
              state_q    <= StScan;
            end else if (full) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        StScan: begin
          if (!issue && !rd_vld_q) begin
            state_q <= StProc;
          end
        end
        StProc: begin
          if (!best_vld_q) begin
            state_q <= StFlush;
          end else if (proc_go) begin
            used_q[best_idx_q] <= 1'b1;
            if (!drop) begin
              kept_q <= 1'b1;
            end
            iss_q      <= '0;
            best_vld_q <= 1'b0;
            state_q    <= StScan;
          end
        end
        StFlush: begin
          if (flush_go) begin
            state_q <= StLoad;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_len_q, out_off_q};
  assign m_axis_tuser  = {out_ovf_q, out_empty_q};
  assign m_axis_tlast  = out_last_q;

`include "read_range_coalescer_macros.svh"

  `RRC_ASSERT(a_cnt_range, cnt_q <= CntMax, "load count above capacity")
  `RRC_ASSERT(a_best_idx, !best_vld_q || (CW'(best_idx_q) < n_q), "picked entry not loaded")
  `RRC_ASSERT(a_empty_last, !out_vld_q || !out_empty_q || out_last_q, "empty result not last")
  `RRC_ASSERT_NEXT(a_flush_done, flush_go, (state_q == StLoad) && out_vld_q && out_last_q, "flush did not finish")

endmodule

/* dv/read_range_coalescer_tb.sv */
module read_range_coalescer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrc_pkg::*;

  typedef struct {
    logic [47:0] off;
    logic [47:0] len;
    bit          last;
    bit          empty;
    bit          ovf;
  } run_t;

  class run_scoreboard;
    logic [47:0] set_offs[$];
    logic [31:0] set_lens[$];
    bit          set_ovf;
    logic [31:0] hole_limit;
    logic [31:0] span_limit;
    run_t        expected_runs[$];
    int          errors;

    function new();
      hole_limit = HoleLimitRst;
      span_limit = SpanLimitRst;
      set_ovf    = 0;
      errors     = 0;
    endfunction

    function void note_range(logic [47:0] off, logic [31:0] len, bit last);
      logic [63:0] so[$], sl[$], ko[$], kl[$];
      logic [63:0] o, l, start, prev_end, cs, ce;
      bit          gap_big, span_big;
      int          j, first_run;
      run_t        r;
      if (set_offs.size() < MaxRangesDef) begin
        set_offs = {set_offs, off};
        set_lens = {set_lens, len};
      end else begin
        set_ovf = 1;
      end
      if (!last) return;
      // insertion sort by offset, longest first on ties
      foreach (set_offs[i]) begin
        o = set_offs[i];
        l = set_lens[i];
        if (l == 0) continue;
        j = so.size();
        while (j > 0 && (o < so[j-1] || (o == so[j-1] && l > sl[j-1]))) j--;
        so.insert(j, o);
        sl.insert(j, l);
      end
      // drop ranges covered by the last kept one
      foreach (so[i]) begin
        if (ko.size() > 0 && so[i] + sl[i] <= ko[$] + kl[$]) continue;
        ko = {ko, so[i]};
        kl = {kl, sl[i]};
      end
      first_run = expected_runs.size();
      r.empty = 0;
      r.ovf   = set_ovf;
      r.last  = 0;
      if (ko.size() == 0) begin
        r.off = '0;
        r.len = '0;
        r.empty = 1;
        expected_runs = {expected_runs, r};
      end else begin
        start = ko[0];
        prev_end = start;
        foreach (ko[i]) begin
          cs = ko[i];
          ce = cs + kl[i];
          gap_big  = cs > prev_end && cs - prev_end > hole_limit;
          span_big = ce - start > span_limit;
          if (gap_big || span_big) begin
            if (prev_end > start) begin
              r.off = start[47:0];
              r.len = 48'(prev_end - start);
              expected_runs = {expected_runs, r};
            end
            start = cs;
          end
          prev_end = ce;
        end
        if (prev_end > start) begin
          r.off = start[47:0];
          r.len = 48'(prev_end - start);
          expected_runs = {expected_runs, r};
        end
      end
      if (expected_runs.size() > first_run) expected_runs[$].last = 1;
      set_offs.delete();
      set_lens.delete();
      set_ovf = 0;
    endfunction

    function void check_run(run_t got);
      run_t want;
      if (expected_runs.size() == 0) begin
        $error("unexpected run: offset %h length %h", got.off, got.len);
        errors++;
        return;
      end
      want = expected_runs.pop_front();
      if (got.off !== want.off) begin
        $error("run_offset: expected %h, actual %h", want.off, got.off);
        errors++;
      end
      if (got.len !== want.len) begin
        $error("run_length: expected %h, actual %h", want.len, got.len);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_out: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
      if (got.empty !== want.empty) begin
        $error("empty_set: expected %0b, actual %0b", want.empty, got.empty);
        errors++;
      end
      if (got.ovf !== want.ovf) begin
        $error("overflow: expected %0b, actual %0b", want.ovf, got.ovf);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              s_axis_tvalid = 0;
  logic              s_axis_tready;
  logic [79:0]       s_axis_tdata = '0;
  logic              s_axis_tlast = 0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 0;
  logic [95:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              m_axis_tlast;
  logic              cfg_valid = 0;
  logic              cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = RegHoleLimit;
  logic [LimW-1:0]   cfg_data = '0;

  run_scoreboard runs_sb = new();
  bit            quiet = 0;
  int            items_sent = 0;
  longint        cycles = 0;

  read_range_coalescer dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  always @(posedge clk_i) begin
    run_t got;
    cycles++;
    if (cycles > 2_000_000) begin
      $display("read_range_coalescer_tb: done, errors");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.off   = m_axis_tdata[47:0];
      got.len   = m_axis_tdata[95:48];
      got.last  = m_axis_tlast;
      got.empty = m_axis_tuser[0];
      got.ovf   = m_axis_tuser[1];
      runs_sb.check_run(got);
    end
  end

  // receiver: random stall before each run
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_range(logic [47:0] off, logic [31:0] len, bit last);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {len, off};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    runs_sb.note_range(off, len, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (runs_sb.expected_runs.size() > 0) @(negedge clk_i);
    // idle time after the last expected run has been taken
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [LimW-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == RegHoleLimit) runs_sb.hole_limit = val;
    else runs_sb.span_limit = val;
    @(negedge clk_i);
  endtask

  task automatic set_limits(logic [31:0] hole, logic [31:0] span);
    drain();
    write_reg(RegHoleLimit, hole);
    write_reg(RegSpanLimit, span);
    cfg_valid <= 0;
  endtask

  function automatic logic [47:0] rand_off(logic [47:0] base);
    if ($urandom_range(0, 3) == 0) return 48'({$urandom, $urandom});
    return base + 48'($urandom_range(0, 20000));
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return $urandom;
      2:       return $urandom_range(1, 20);
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  initial begin
    int          n;
    logic [47:0] base;
    logic [31:0] span;
    repeat (11) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: empty set, extreme range, ties, cover, zero length, gap at limit
    send_range(48'd500, 32'd0, 1);
    send_range(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_range(48'd1000, 32'd100, 0);
    send_range(48'd1000, 32'd500, 0);
    send_range(48'd1200, 32'd50, 0);
    send_range(48'd7, 32'd0, 0);
    send_range(48'd1400, 32'd300, 0);
    send_range(48'd1700 + 48'd8192, 32'd10, 0);
    send_range(48'd9902 + 48'd8193, 32'd10, 1);
    set_limits(32'd0, 32'd1);
    send_range(48'd100, 32'd10, 0);
    send_range(48'd110, 32'd1, 0);
    send_range(48'd111, 32'd5, 1);
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(48'h0, 32'hFFFF_FFFF, 0);
    send_range(48'hFFFF_0000_0000, 32'd20, 0);
    send_range(48'h8000_0000_0000, 32'd1, 1);
    set_limits(32'd0, 32'd300);
    send_range(48'd0, 32'd100, 0);
    send_range(48'd100, 32'd100, 0);
    send_range(48'd200, 32'd100, 0);
    send_range(48'd300, 32'd1, 1);
    set_limits(HoleLimitRst, SpanLimitRst);

    while (items_sent < 400) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: span = 32'd1;
          1: span = 32'hFFFF_FFFF;
          2: span = $urandom_range(1, 30000);
          default: span = $urandom | 32'd1;
        endcase
        case ($urandom_range(0, 3))
          0: set_limits(32'd0, span);
          1: set_limits(32'hFFFF_FFFF, span);
          2: set_limits($urandom_range(0, 3000), span);
          default: set_limits($urandom, span);
        endcase
      end else if ($urandom_range(0, 15) == 0) begin
        drain();
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 8);
      base = 48'({$urandom, $urandom});
      if ($urandom_range(0, 5) == 0) base = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 30000));
      for (int i = 0; i < n; i++) send_range(rand_off(base), rand_len(), i == n - 1);
    end

    quiet = 0;
    drain();
    if (runs_sb.errors == 0) begin
      $display("read_range_coalescer_tb: done, clean");
    end else begin
      $display("read_range_coalescer_tb: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rrc_pkg.sv
rtl/read_range_coalescer.sv
dv/read_range_coalescer_tb.sv
